// ===== hdl/fan_curve_with_led_soft_pwm_top_defines.svh =====
// Assertion macros shared by the fan curve RTL.
// Depends on nothing; included by the top level only.
`ifndef FAN_CURVE_WITH_LED_SOFT_PWM_TOP_DEFINES_SVH
`define FAN_CURVE_WITH_LED_SOFT_PWM_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FCL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fan curve check failed");

// Next-cycle implication, disabled while reset is high.
`define FCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fan curve check failed");

`endif

// ===== hdl/fcl_pkg.sv =====
// Widths, reset values, register indexes and arithmetic constants of the fan curve block.
// Depends on nothing; used by the interfaces and all modules.
package fcl_pkg;

  localparam int SampleW   = 10;
  localparam int LevelW    = 11;
  localparam int PwmW      = 7;
  localparam int SampleCntW = 16;
  localparam int UpdateCntW = 18;
  localparam int CfgDataW  = 18;
  localparam int CfgIdxW   = 3;

  localparam logic [SampleW-1:0]    TempLowReset    = 10'd370;
  localparam logic [PwmW-1:0]       LedPeriodReset  = 7'd100;
  localparam logic [SampleCntW-1:0] SampleIntReset  = 16'd2000;
  localparam logic [UpdateCntW-1:0] UpdateIntReset  = 18'd200000;
  localparam logic [PwmW-1:0]       BlueLevelReset  = 7'd50;

  localparam logic [PwmW-1:0] DutyFull  = 7'd80;
  localparam logic [PwmW-1:0] LevelMax  = 7'd100;
  localparam logic [PwmW-1:0] DutyBase  = 7'd15;
  localparam logic [PwmW-1:0] DutyKnee  = 7'd10;

  // floor(y / 10) = (y * 6554) >> 16 for y below 10240.
  localparam logic [12:0] Recip10      = 13'd6554;
  localparam int          Recip10Shift = 16;
  // floor(p / 90) = (p * 11651) >> 20 for p up to 5850.
  localparam logic [13:0] Recip90      = 14'd11651;
  localparam int          Recip90Shift = 20;

  typedef enum logic [CfgIdxW-1:0] {
    RegTempLow    = 3'd0,
    RegLedPeriod  = 3'd1,
    RegSampleInt  = 3'd2,
    RegUpdateInt  = 3'd3,
    RegBlueLevel  = 3'd4
  } reg_idx_t;

endpackage

// ===== hdl/fcl_in_if.sv =====
// Input channel: one timer tick word carrying a temperature sample.
// Depends on fcl_pkg.
interface fcl_in_if import fcl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] adc_sample;

  modport source(output valid, output adc_sample, input ready);
  modport sink(input valid, input adc_sample, output ready);
endinterface

// ===== hdl/fcl_out_if.sv =====
// Output channel: fan duty and the three LED pin levels for one tick.
// Depends on fcl_pkg.
interface fcl_out_if import fcl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PwmW-1:0] fan_duty;
  logic            red_out;
  logic            green_out;
  logic            blue_out;

  modport source(output valid, output fan_duty, output red_out, output green_out,
                 output blue_out, input ready);
  modport sink(input valid, input fan_duty, input red_out, input green_out,
               input blue_out, output ready);
endinterface

// ===== hdl/fcl_duty_map.sv =====
// Piecewise map from the signed fan level to the fan duty and the clamped LED level.
// Depends on fcl_pkg.
module fcl_duty_map import fcl_pkg::*; (
  input  logic signed [LevelW-1:0] level,
  output logic        [PwmW-1:0]   duty,
  output logic        [PwmW-1:0]   led_level
);

  logic            below_one;
  logic            negative;
  logic            above_max;
  logic [PwmW-1:0] mid;
  logic            upper;
  logic [PwmW-1:0] span;
  logic [12:0]     scaled;
  logic [26:0]     recip;
  logic [PwmW-1:0] quot;
  logic [PwmW-1:0] curve;

  always_comb begin
    negative  = level[LevelW-1];
    below_one = negative || (level == '0);
    above_max = !negative && (level[LevelW-2:0] > 10'(LevelMax));
    mid       = level[PwmW-1:0];
    upper     = mid >= DutyKnee;
    span      = upper ? (mid - DutyKnee) : (DutyKnee - mid);
    // Times 65 as a shift and add.
    scaled    = {span, 6'b0} + 13'(span);
    recip     = 27'(scaled) * 27'(Recip90);
    quot      = recip[Recip90Shift +: PwmW];
    curve     = upper ? (DutyBase + quot) : (DutyBase - quot);

    if (below_one) begin
      duty = '0;
    end else if (above_max) begin
      duty = DutyFull;
    end else begin
      duty = curve;
    end

    if (negative) begin
      led_level = '0;
    end else if (above_max) begin
      led_level = LevelMax;
    end else begin
      led_level = mid;
    end
  end

endmodule

// ===== hdl/fan_curve_with_led_soft_pwm_top.sv =====
// Channel   Direction  Payload                                    Handshake
// tick      in         adc_sample[9:0]                            valid / ready
// result    out        fan_duty[6:0], red_out, green_out, blue_out valid / ready
// cfg       in         cfg_index[2:0], cfg_data[17:0]              cfg_we, no wait
//
// One result word per tick word; one tick per cycle sustained while results are read. A tick
// is held in the input register, then the counters, filter and level map update in a single
// pass into the result register. Reset (rst, synchronous) loads the register defaults and
// full fan speed. A stalled result holds a full input register; a tick is taken while the
// input register is empty or the result register is empty or being read.
//
// Top level of the fan curve block; depends on fcl_pkg, fcl_in_if, fcl_out_if,
// fcl_duty_map and the assertion macro header.
`include "fan_curve_with_led_soft_pwm_top_defines.svh"

module fan_curve_with_led_soft_pwm_top import fcl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  fcl_in_if.sink              tick,
  fcl_out_if.source           result,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [SampleW-1:0]    temp_low;
  logic [PwmW-1:0]       led_period;
  logic [SampleCntW-1:0] sample_interval;
  logic [UpdateCntW-1:0] update_interval;
  logic [PwmW-1:0]       blue_level;

  logic                  in_valid;
  logic [SampleW-1:0]    in_sample;
  logic                  res_valid;
  logic                  advance;
  logic                  fire;

  logic [UpdateCntW-1:0]     update_count;
  logic [SampleCntW-1:0]     sample_count;
  logic [PwmW-1:0]           led_count;
  logic [SampleW-1:0]        smoothed_temp;
  logic signed [LevelW-1:0]  fan_level;
  logic [PwmW-1:0]           duty_reg;
  logic [PwmW-1:0]           red_level;
  logic [PwmW-1:0]           green_level;
  logic [PwmW-1:0]           blue_hold;

  logic [UpdateCntW-1:0]     update_count_next;
  logic [SampleCntW-1:0]     sample_count_next;
  logic [PwmW-1:0]           led_count_next;
  logic [SampleW-1:0]        smoothed_temp_next;
  logic signed [LevelW-1:0]  fan_level_next;
  logic [PwmW-1:0]           duty_reg_next;
  logic [PwmW-1:0]           red_level_next;
  logic [PwmW-1:0]           green_level_next;
  logic [PwmW-1:0]           blue_hold_next;

  logic [UpdateCntW-1:0] update_inc;
  logic [SampleCntW-1:0] sample_inc;
  logic [PwmW-1:0]       led_inc;
  logic                  do_update;
  logic                  do_sample;
  logic [13:0]           old_scaled;
  logic [26:0]           old_recip;
  logic [25:0]           new_recip;
  logic [SampleW:0]      avg_sum;
  logic [PwmW-1:0]       map_duty;
  logic [PwmW-1:0]       map_level;
  logic [PwmW-1:0]       blue_clamped;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_low        <= TempLowReset;
      led_period      <= LedPeriodReset;
      sample_interval <= SampleIntReset;
      update_interval <= UpdateIntReset;
      blue_level      <= BlueLevelReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegTempLow:   temp_low        <= cfg_data[SampleW-1:0];
        RegLedPeriod: led_period      <= cfg_data[PwmW-1:0];
        RegSampleInt: sample_interval <= cfg_data[SampleCntW-1:0];
        RegUpdateInt: update_interval <= cfg_data[UpdateCntW-1:0];
        RegBlueLevel: blue_level      <= cfg_data[PwmW-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = !res_valid || result.ready;
  assign fire       = in_valid && advance;
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      in_sample <= tick.adc_sample;
    end
  end

  fcl_duty_map u_duty_map (
    .level     (fan_level),
    .duty      (map_duty),
    .led_level (map_level)
  );

  always_comb begin
    update_inc = update_count + 1'b1;
    sample_inc = sample_count + 1'b1;
    led_inc    = led_count + 1'b1;
    do_update  = update_inc >= update_interval;
    do_sample  = sample_inc > sample_interval;

    blue_clamped = (blue_level > LevelMax) ? LevelMax : blue_level;

    // Nine tenths of the old average and one tenth of the sample, each truncated.
    old_scaled = {smoothed_temp, 3'b0} + 14'(smoothed_temp);
    old_recip  = 27'(old_scaled) * 27'(Recip10);
    new_recip  = 26'(in_sample) * 26'(Recip10);
    avg_sum    = 11'(old_recip[Recip10Shift +: SampleW])
               + 11'(new_recip[Recip10Shift +: SampleW]);

    update_count_next  = update_inc;
    duty_reg_next      = duty_reg;
    red_level_next     = red_level;
    green_level_next   = green_level;
    blue_hold_next     = blue_hold;
    if (do_update) begin
      update_count_next = '0;
      duty_reg_next     = map_duty;
      red_level_next    = map_level;
      green_level_next  = map_level;
      blue_hold_next    = blue_clamped;
    end

    sample_count_next  = sample_inc;
    smoothed_temp_next = smoothed_temp;
    fan_level_next     = fan_level;
    if (do_sample) begin
      sample_count_next  = '0;
      smoothed_temp_next = avg_sum[SampleW-1:0];
      fan_level_next     = $signed({1'b0, avg_sum[SampleW-1:0]})
                         - $signed({1'b0, temp_low});
    end

    led_count_next = (led_inc >= led_period) ? '0 : led_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      update_count  <= '0;
      sample_count  <= '0;
      led_count     <= '0;
      smoothed_temp <= '0;
      fan_level     <= '0;
      duty_reg      <= DutyFull;
      red_level     <= '0;
      green_level   <= '0;
      blue_hold     <= '0;
    end else if (fire) begin
      update_count  <= update_count_next;
      sample_count  <= sample_count_next;
      led_count     <= led_count_next;
      smoothed_temp <= smoothed_temp_next;
      fan_level     <= fan_level_next;
      duty_reg      <= duty_reg_next;
      red_level     <= red_level_next;
      green_level   <= green_level_next;
      blue_hold     <= blue_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.fan_duty  <= duty_reg_next;
      result.red_out   <= led_count_next >= red_level_next;
      result.green_out <= led_count_next >= green_level_next;
      result.blue_out  <= led_count_next >= blue_hold_next;
    end
  end

  assign result.valid = res_valid;

  `FCL_ASSERT_NEXT(a_fire_gives_result, clk, rst, fire, res_valid)
  `FCL_ASSERT_NOW(a_ready_when_empty, clk, rst, !res_valid, tick.ready)
  `FCL_ASSERT_NOW(a_levels_clamped, clk, rst, 1'b1, (red_level <= LevelMax) && (blue_hold <= LevelMax))
  `FCL_ASSERT_NOW(a_duty_range, clk, rst, res_valid, result.fan_duty <= DutyFull)

endmodule

// ===== dv/fan_curve_with_led_soft_pwm_top_tb.sv =====
// Self-checking testbench for the fan curve block with soft-PWM LED outputs.
// Drives tick words with random gaps, predicts every result word and checks it.
// Depends on fcl_pkg, fcl_in_if, fcl_out_if and fan_curve_with_led_soft_pwm_top.
`timescale 1ns / 1ps

module fan_curve_with_led_soft_pwm_top_tb;
  import fcl_pkg::*;

  localparam int CycleLimit = 600000;
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  typedef struct packed {
    logic [PwmW-1:0] duty;
    logic            red;
    logic            green;
    logic            blue;
  } pins_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  fcl_in_if  tick_if();
  fcl_out_if res_if();

  fan_curve_with_led_soft_pwm_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick_if),
    .result   (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  logic [SampleW-1:0]    lo_temp;
  logic [PwmW-1:0]       pwm_len;
  logic [SampleCntW-1:0] filt_every;
  logic [UpdateCntW-1:0] refresh_every;
  logic [PwmW-1:0]       blue_set;

  logic [UpdateCntW-1:0] tick_age;
  logic [SampleCntW-1:0] filt_age;
  logic [PwmW-1:0]       pwm_phase;
  logic [SampleW-1:0]    avg_temp;
  int                    heat_level;
  logic [PwmW-1:0]       duty_now;
  logic [PwmW-1:0]       red_thr;
  logic [PwmW-1:0]       green_thr;
  logic [PwmW-1:0]       blue_thr;

  logic [SampleW-1:0] tick_q[$];
  pins_t              pins_due[$];

  int   err_count = 0;
  int   res_count = 0;
  int   cycles = 0;
  int   src_gap = 0;
  int   snk_gap = 0;
  bit   src_calm = 0;
  bit   snk_calm = 0;
  int   hold_left = 0;
  int   holds_done = 0;
  logic word_taken = 1'b0;

  function automatic logic [PwmW-1:0] clip_level(int v);
    if (v < 0) return '0;
    if (v > int'(LevelMax)) return LevelMax;
    return v[PwmW-1:0];
  endfunction

  function automatic logic [PwmW-1:0] duty_for(int v);
    int d;
    if (v < 1) return '0;
    if (v > int'(LevelMax)) return DutyFull;
    d = (v - 10) * 65 / 90 + 15;
    return d[PwmW-1:0];
  endfunction

  function automatic pins_t advance_curve(logic [SampleW-1:0] s);
    int    t;
    pins_t r;
    tick_age  = tick_age + 1'b1;
    filt_age  = filt_age + 1'b1;
    pwm_phase = pwm_phase + 1'b1;
    if (tick_age >= refresh_every) begin
      tick_age  = '0;
      duty_now  = duty_for(heat_level);
      red_thr   = clip_level(heat_level);
      green_thr = red_thr;
      blue_thr  = clip_level(int'(blue_set));
    end
    if (filt_age > filt_every) begin
      filt_age   = '0;
      t          = (int'(avg_temp) * 90) / 100 + (int'(s) * 10) / 100;
      avg_temp   = t[SampleW-1:0];
      heat_level = int'(avg_temp) - int'(lo_temp);
    end
    if (pwm_phase >= pwm_len) pwm_phase = '0;
    r.duty  = duty_now;
    r.red   = (pwm_phase >= red_thr);
    r.green = (pwm_phase >= green_thr);
    r.blue  = (pwm_phase >= blue_thr);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Tick driver.
  always @(negedge clk) begin
    if (rst) begin
      tick_if.valid <= 1'b0;
    end else if (!tick_if.valid || word_taken) begin
      if (src_gap != 0) begin
        tick_if.valid <= 1'b0;
        src_gap--;
      end else if (tick_q.size() != 0) begin
        tick_if.valid      <= 1'b1;
        tick_if.adc_sample <= tick_q.pop_front();
        if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
        src_gap = src_calm ? 0 : pick_gap();
      end else begin
        tick_if.valid <= 1'b0;
      end
    end
  end

  // Result ready pattern.
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_if.ready <= 1'b0;
    end else if (snk_gap != 0) begin
      res_if.ready <= 1'b0;
      snk_gap--;
    end else begin
      res_if.ready <= 1'b1;
      if ($urandom_range(0, 49) == 0) snk_calm = !snk_calm;
      if (!snk_calm && $urandom_range(0, 3) == 0) snk_gap = pick_gap();
    end
  end

  // Long receiver hold-offs so that the block fills and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && res_count >= 200) ||
                 (holds_done == 1 && res_count >= 700)) begin
      hold_left  <= 120;
      holds_done <= holds_done + 1;
    end
  end

  // Result checker and predictor.
  always @(posedge clk) begin
    pins_t seen;
    pins_t want;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= tick_if.valid && tick_if.ready;
      if (res_if.valid && res_if.ready) begin
        seen = {res_if.fan_duty, res_if.red_out, res_if.green_out, res_if.blue_out};
        res_count <= res_count + 1;
        if (pins_due.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result word: duty %0d r %0b g %0b b %0b",
                     seen.duty, seen.red, seen.green, seen.blue);
          err_count++;
        end else begin
          want = pins_due.pop_front();
          if (seen.duty !== want.duty || seen.red !== want.red ||
              seen.green !== want.green || seen.blue !== want.blue) begin
            if (err_count < 10)
              $display({"mismatch at word %0d: expected duty %0d r %0b g %0b b %0b,",
                        " got duty %0d r %0b g %0b b %0b"},
                       res_count, want.duty, want.red, want.green, want.blue,
                       seen.duty, seen.red, seen.green, seen.blue);
            err_count++;
          end
        end
      end
      if (tick_if.valid && tick_if.ready)
        pins_due.push_back(advance_curve(tick_if.adc_sample));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      RegTempLow:   lo_temp       = val[SampleW-1:0];
      RegLedPeriod: pwm_len       = val[PwmW-1:0];
      RegSampleInt: filt_every    = val[SampleCntW-1:0];
      RegUpdateInt: refresh_every = val[UpdateCntW-1:0];
      RegBlueLevel: blue_set      = val[PwmW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(int tl, int lp, int si, int ui, int bl);
    write_reg(RegTempLow, CfgDataW'(tl));
    write_reg(RegLedPeriod, CfgDataW'(lp));
    write_reg(RegSampleInt, CfgDataW'(si));
    write_reg(RegUpdateInt, CfgDataW'(ui));
    write_reg(RegBlueLevel, CfgDataW'(bl));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (tick_q.size() != 0 || tick_if.valid || pins_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_temps(int n, int base);
    int aim;
    int left;
    int v;
    aim  = base;
    left = 0;
    for (int k = 0; k < n; k++) begin
      if (left == 0) begin
        left = $urandom_range(15, 60);
        case ($urandom_range(0, 9))
          0: aim = 0;
          1: aim = 1023;
          default: aim = base + int'($urandom_range(0, 150)) - 20;
        endcase
      end
      left--;
      if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1023);
      else v = aim + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      tick_q.push_back(v[SampleW-1:0]);
    end
  endtask

  initial begin
    tick_if.valid      = 1'b0;
    tick_if.adc_sample = '0;
    res_if.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    rst                = 1'b1;

    lo_temp       = TempLowReset;
    pwm_len       = LedPeriodReset;
    filt_every    = SampleIntReset;
    refresh_every = UpdateIntReset;
    blue_set      = BlueLevelReset;
    tick_age      = '0;
    filt_age      = '0;
    pwm_phase     = '0;
    avg_temp      = '0;
    heat_level    = 0;
    duty_now      = DutyFull;
    red_thr       = '0;
    green_thr     = '0;
    blue_thr      = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tick_q = '{10'd0, 10'd1023, 10'd512};
    drain();

    // Zero intervals, a one-tick LED period and a blue level above range.
    write_reg(RegSpare, '1);
    set_all(0, 1, 0, 0, 127);
    tick_q = '{10'd1023, 10'd1023, 10'd1023, 10'd0};
    drain();

    // Largest intervals, so the sample counter wraps before it can exceed its limit.
    set_all(1023, 0, 65535, 262143, 0);
    tick_q = '{10'd0, 10'd1023, 10'd341};
    drain();

    // The update interval drops below the running count and fires at once.
    set_all(0, 127, 1, 1, 100);
    tick_q = '{10'd682, 10'd1023, 10'd5, 10'd1023};
    drain();

    set_all(370, 100, 2000, 200000, 50);
    queue_temps(100, 370);
    drain();

    set_all(370, 7, 1, 3, 30);
    queue_temps(300, 370);
    drain();

    set_all(100, 127, 2, 5, 100);
    queue_temps(200, 100);
    drain();

    set_all(600, 1, 3, 1, 0);
    queue_temps(150, 600);
    drain();

    for (int p = 0; p < 4; p++) begin
      int tl;
      tl = $urandom_range(0, 1023);
      set_all(tl, $urandom_range(1, 127), $urandom_range(1, 4), $urandom_range(1, 8),
              $urandom_range(0, 100));
      queue_temps(100, tl);
      drain();
    end

    repeat (10) @(negedge clk);
    if (err_count == 0 && pins_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fcl_pkg.sv
hdl/fcl_in_if.sv
hdl/fcl_out_if.sv
hdl/fcl_duty_map.sv
hdl/fan_curve_with_led_soft_pwm_top.sv
dv/fan_curve_with_led_soft_pwm_top_tb.sv
